>>> sv/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, idle during reset.
`define ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, idle during reset.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> sv/sfbp_pkg.sv
package sfbp_pkg;

  localparam int POOL_DEPTH = 16;
  localparam int IDX_W = $clog2(POOL_DEPTH);
  localparam int CNT_W = $clog2(POOL_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_FLUSH = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    K_HIT         = 3'd0,
    K_MISS        = 3'd1,
    K_FREE_KEPT   = 3'd2,
    K_FREE_REL    = 3'd3,
    K_FLUSH_ENTRY = 3'd4,
    K_FLUSH_EMPTY = 3'd5
  } kind_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] size_bytes;
    logic [3:0]  align_log2;
    logic [47:0] block_address;
    logic [31:0] block_capacity;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [47:0] address;
    logic [31:0] capacity;
    logic        pool_full;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [47:0] address;
    logic [31:0] capacity;
  } entry_t;

endpackage

>>> sv/sorted_free_block_pool.sv
// Channel   Handshake              Payload
// command   start / busy           cmd (opcode, size, alignment, block)
// result    strobe, one cycle      result (kind, address, capacity, flags)
//
// Steps: a released free or an empty flush answers straight from idle. Each entry
// scanned is read, then compared; each entry moved to close or open a gap is read,
// then written; a kept free ends with an insert write, and a miss doubles the
// alignment until it covers the request. The registered table read sets these steps.
// Reset clears the fill count and the control state; the memory itself is never cleared.
// The receiver cannot stall: each result is shown for exactly one cycle.
module sorted_free_block_pool (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  sfbp_pkg::cmd_t    cmd,
  output logic             busy,
  output logic             strobe,
  output sfbp_pkg::result_t result
);
  import sfbp_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_RD    = 7'b0000010,
    S_EV    = 7'b0000100,
    S_GROW  = 7'b0001000,
    S_SD_RD = 7'b0010000,
    S_SD_WR = 7'b0100000,
    S_SU_RD = 7'b1000000
  } state_t;

  // Table memory: entries packed from index 0, sorted by capacity.
  entry_t mem [POOL_DEPTH];
  entry_t rd_data;
  logic [IDX_W-1:0] ra;
  logic [IDX_W-1:0] wa;
  entry_t wd;
  logic we;

  state_t state;
  logic su_wr;         // second half of a shift-up move
  logic ins;           // final insert of a free
  cmd_t req;
  logic [CNT_W-1:0] cnt;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] pos;
  logic [32:0] need;

  logic [31:0] mask;
  logic at_end;
  logic fit;

  assign busy = (state != S_IDLE) || su_wr || ins;
  assign mask = (32'd1 << req.align_log2) - 32'd1;
  assign at_end = (CNT_W'(idx) + CNT_W'(1)) == cnt;
  assign fit = (rd_data.capacity >= req.size_bytes) &&
               ((rd_data.address[31:0] & mask) == 32'd0) &&
               ((rd_data.capacity & mask) == 32'd0);

  // Read address per state; writes come from the move and insert steps.
  always_comb begin
    ra = idx;
    if (state == S_SD_RD) begin
      ra = IDX_W'(idx + IDX_W'(1));
    end
    we = 1'b0;
    wa = idx;
    wd = rd_data;
    if (state == S_SD_WR) begin
      we = 1'b1;
    end else if (su_wr) begin
      we = 1'b1;
      wa = IDX_W'(idx + IDX_W'(1));
    end else if (ins) begin
      we = 1'b1;
      wa = pos;
      wd = '{address: req.block_address, capacity: req.block_capacity};
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data <= mem[ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      su_wr  <= 1'b0;
      ins    <= 1'b0;
      cnt    <= '0;
      strobe <= 1'b0;
    end else begin
      strobe <= 1'b0;
      su_wr  <= 1'b0;
      ins    <= 1'b0;
      if (ins) begin
        // Drop the freed block into its gap and report it kept.
        cnt    <= cnt + CNT_W'(1);
        strobe <= 1'b1;
        result <= '{kind: K_FREE_KEPT, address: '0, capacity: '0,
                    pool_full: (cnt + CNT_W'(1)) == CNT_W'(POOL_DEPTH), last: 1'b1};
      end else if (su_wr) begin
        // Entry idx moved to idx+1; continue down to the insert point.
        if (idx == pos) begin
          ins <= 1'b1;
        end else begin
          idx   <= idx - IDX_W'(1);
          state <= S_SU_RD;
        end
      end else begin
        case (state)
          S_IDLE: begin
            if (start) begin
              req  <= cmd;
              idx  <= '0;
              need <= 33'(33'd1 << cmd.align_log2);
              case (cmd.opcode)
                OP_ALLOC: begin
                  state <= (cnt == '0) ? S_GROW : S_RD;
                end
                OP_FREE: begin
                  if (cmd.block_address == '0 || cnt == CNT_W'(POOL_DEPTH)) begin
                    strobe <= 1'b1;
                    result <= '{kind: K_FREE_REL, address: cmd.block_address,
                                capacity: '0, pool_full: cnt == CNT_W'(POOL_DEPTH),
                                last: 1'b1};
                  end else if (cnt == '0) begin
                    pos <= '0;
                    ins <= 1'b1;
                  end else begin
                    state <= S_RD;
                  end
                end
                OP_FLUSH: begin
                  if (cnt == '0) begin
                    strobe <= 1'b1;
                    result <= '{kind: K_FLUSH_EMPTY, address: '0, capacity: '0,
                                pool_full: 1'b0, last: 1'b1};
                  end else begin
                    state <= S_RD;
                  end
                end
                default: ;
              endcase
            end
          end
          S_RD: begin
            state <= S_EV;
          end
          S_EV: begin
            case (req.opcode)
              OP_ALLOC: begin
                if (fit) begin
                  strobe <= 1'b1;
                  result <= '{kind: K_HIT, address: rd_data.address,
                              capacity: rd_data.capacity, pool_full: 1'b0, last: 1'b1};
                  if (at_end) begin
                    cnt   <= cnt - CNT_W'(1);
                    state <= S_IDLE;
                  end else begin
                    state <= S_SD_RD;
                  end
                end else if (at_end) begin
                  state <= S_GROW;
                end else begin
                  idx   <= idx + IDX_W'(1);
                  state <= S_RD;
                end
              end
              OP_FREE: begin
                if (rd_data.capacity > req.block_capacity) begin
                  // Open a gap at idx: move the tail up one place.
                  pos   <= idx;
                  idx   <= IDX_W'(cnt - CNT_W'(1));
                  state <= S_SU_RD;
                end else if (at_end) begin
                  pos   <= IDX_W'(cnt);
                  ins   <= 1'b1;
                  state <= S_IDLE;
                end else begin
                  idx   <= idx + IDX_W'(1);
                  state <= S_RD;
                end
              end
              default: begin
                strobe <= 1'b1;
                result <= '{kind: K_FLUSH_ENTRY, address: rd_data.address,
                            capacity: rd_data.capacity, pool_full: 1'b0, last: at_end};
                if (at_end) begin
                  cnt   <= '0;
                  state <= S_IDLE;
                end else begin
                  idx   <= idx + IDX_W'(1);
                  state <= S_RD;
                end
              end
            endcase
          end
          S_GROW: begin
            // Double the alignment until it covers the size.
            if (need >= {1'b0, req.size_bytes}) begin
              strobe <= 1'b1;
              result <= '{kind: K_MISS, address: '0,
                          capacity: need[32] ? 32'd0 : need[31:0],
                          pool_full: cnt == CNT_W'(POOL_DEPTH), last: 1'b1};
              state  <= S_IDLE;
            end else begin
              need <= need << 1;
            end
          end
          S_SD_RD: begin
            state <= S_SD_WR;
          end
          S_SD_WR: begin
            // Entry idx+1 now sits at idx; close the gap up to the tail.
            if ((CNT_W'(idx) + CNT_W'(2)) == cnt) begin
              cnt   <= cnt - CNT_W'(1);
              state <= S_IDLE;
            end else begin
              idx   <= idx + IDX_W'(1);
              state <= S_SD_RD;
            end
          end
          S_SU_RD: begin
            su_wr <= 1'b1;
            state <= S_IDLE;
          end
          default: begin
            state <= S_IDLE;
          end
        endcase
      end
    end
  end

endmodule

>>> sv/sfbp_checker.sv
`include "assert_macros.svh"

module sfbp_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input sfbp_pkg::cmd_t    cmd,
  input logic              busy,
  input logic              strobe,
  input sfbp_pkg::result_t result
);
  import sfbp_pkg::*;

  `ASSERT_SAME(a_hit_not_full, strobe && result.kind == K_HIT, !result.pool_full)
  `ASSERT_SAME(a_empty_flush, strobe && result.kind == K_FLUSH_EMPTY,
               result.last && !result.pool_full)
  `ASSERT_SAME(a_more_busy, strobe && !result.last, busy)
  `ASSERT_NEXT(a_no_op_silent, start && !busy && cmd.opcode == OP_NONE, !strobe)

endmodule

bind sorted_free_block_pool sfbp_checker u_sfbp_checker (.*);

>>> tb/sorted_free_block_pool_tb.sv
module sorted_free_block_pool_tb;
  import sfbp_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 200;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  cmd_t cmd = '0;
  logic busy;
  logic strobe;
  result_t result;

  sorted_free_block_pool dut (
    .clk(clk), .rst(rst), .start(start), .cmd(cmd),
    .busy(busy), .strobe(strobe), .result(result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the free-block table, packed from entry 0, sorted by capacity.
  entry_t shadow_entry [POOL_DEPTH];
  int shadow_count;

  result_t expected_results [$];
  int mismatch_count = 0;
  int row_errors = 0;
  int idle_cycles = 0;
  int gap_percent;

  // Work out the results of one accepted command and update the shadow table.
  function automatic void predict_pool_command(cmd_t c);
    result_t r;
    logic [32:0] align, need;
    int hit_pos, ins_pos, n;
    r = '0;
    hit_pos = -1;
    case (op_t'(c.opcode))
      OP_ALLOC: begin
        align = 33'd1 << c.align_log2;
        for (int i = 0; i < shadow_count; i++) begin
          if (hit_pos < 0 && shadow_entry[i].capacity >= c.size_bytes &&
              (shadow_entry[i].address & (align - 1)) == 0 &&
              ({1'b0, shadow_entry[i].capacity} & (align - 1)) == 0)
            hit_pos = i;
        end
        if (hit_pos >= 0) begin
          r.kind = K_HIT;
          r.address = shadow_entry[hit_pos].address;
          r.capacity = shadow_entry[hit_pos].capacity;
          for (int j = hit_pos; j < shadow_count - 1; j++)
            shadow_entry[j] = shadow_entry[j + 1];
          shadow_count--;
        end else begin
          // Double the alignment until it covers the size; give 0 past 32 bits.
          need = align;
          while (need < {1'b0, c.size_bytes}) need = need << 1;
          r.kind = K_MISS;
          r.capacity = need[32] ? 32'd0 : need[31:0];
        end
        r.pool_full = (shadow_count == POOL_DEPTH);
        r.last = 1'b1;
        expected_results.push_back(r);
      end
      OP_FREE: begin
        if (c.block_address == 0 || shadow_count == POOL_DEPTH) begin
          r.kind = K_FREE_REL;
          r.address = c.block_address;
        end else begin
          // Insert behind every entry of equal capacity.
          ins_pos = shadow_count;
          for (int i = shadow_count - 1; i >= 0; i--)
            if (shadow_entry[i].capacity > c.block_capacity) ins_pos = i;
          for (int j = shadow_count; j > ins_pos; j--)
            shadow_entry[j] = shadow_entry[j - 1];
          shadow_entry[ins_pos] = '{c.block_address, c.block_capacity};
          shadow_count++;
          r.kind = K_FREE_KEPT;
        end
        r.pool_full = (shadow_count == POOL_DEPTH);
        r.last = 1'b1;
        expected_results.push_back(r);
      end
      OP_FLUSH: begin
        n = shadow_count;
        shadow_count = 0;
        if (n == 0) begin
          r.kind = K_FLUSH_EMPTY;
          r.last = 1'b1;
          expected_results.push_back(r);
        end
        for (int i = 0; i < n; i++) begin
          r.kind = K_FLUSH_ENTRY;
          r.address = shadow_entry[i].address;
          r.capacity = shadow_entry[i].capacity;
          r.pool_full = 1'b0;
          r.last = (i == n - 1);
          expected_results.push_back(r);
        end
      end
      default: ;
    endcase
  endfunction

  // Compare every result transfer against the oldest expectation.
  always @(posedge clk) begin
    result_t e;
    if (!rst && strobe) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result kind=%0d address=%h", result.kind, result.address);
        mismatch_count++;
      end else begin
        e = expected_results.pop_front();
        if (result.kind !== e.kind) begin
          $error("kind: expected %0d, got %0d", e.kind, result.kind); mismatch_count++;
        end
        if (result.address !== e.address) begin
          $error("address: expected %h, got %h", e.address, result.address);
          mismatch_count++;
        end
        if (result.capacity !== e.capacity) begin
          $error("capacity: expected %h, got %h", e.capacity, result.capacity);
          mismatch_count++;
        end
        if (result.pool_full !== e.pool_full) begin
          $error("pool_full: expected %b, got %b", e.pool_full, result.pool_full);
          mismatch_count++;
        end
        if (result.last !== e.last) begin
          $error("last: expected %b, got %b", e.last, result.last); mismatch_count++;
        end
      end
    end
  end

  // Watchdog: count cycles with no transfer on either side.
  always @(posedge clk) begin
    if (!rst && !(start && !busy) && !strobe) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end else if (!rst) begin
      idle_cycles <= 0;
    end
  end

  // Hold the command until it is accepted, after a random gap; leave start high
  // across back-to-back transfers.
  task automatic send_command(cmd_t c);
    if ($urandom_range(99) < gap_percent) begin
      start <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < gap_percent) @(posedge clk);
    end
    start <= 1'b1;
    cmd <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_pool_command(c);
  endtask

  function automatic cmd_t make_cmd(op_t op, logic [31:0] size, logic [3:0] alog,
                                    logic [47:0] addr, logic [31:0] cap);
    cmd_t c;
    c.opcode = op;
    c.size_bytes = size;
    c.align_log2 = alog;
    c.block_address = addr;
    c.block_capacity = cap;
    return c;
  endfunction

  function automatic cmd_t random_cmd();
    cmd_t c;
    logic [127:0] raw;
    int pick;
    raw = {$urandom, $urandom, $urandom, $urandom};
    c = raw[$bits(cmd_t)-1:0];
    pick = $urandom_range(99);
    // Mostly frees and allocates with small, aligned-friendly values.
    if (pick < 45) begin
      c.opcode = OP_FREE;
      if ($urandom_range(3) != 0) begin
        c.block_address = 48'($urandom_range(255)) << $urandom_range(12);
        c.block_capacity = 32'($urandom_range(64)) << $urandom_range(10);
      end
    end else if (pick < 85) begin
      c.opcode = OP_ALLOC;
      if ($urandom_range(3) != 0) begin
        c.size_bytes = 32'($urandom_range(4096));
        c.align_log2 = 4'($urandom_range(12));
      end
    end else if (pick < 95) begin
      c.opcode = OP_FLUSH;
    end else begin
      c.opcode = OP_NONE;
    end
    return c;
  endfunction

  // Directed rows; the expected column is filled only where it is obvious.
  typedef struct {
    cmd_t c;
    logic check_it;
    result_t r;
  } directed_row_t;

  directed_row_t directed_rows [$];

  task automatic add_row(cmd_t c, logic check_it, result_t r);
    directed_row_t d;
    d.c = c; d.check_it = check_it; d.r = r;
    directed_rows.push_back(d);
  endtask

  initial begin
    cmd_t c;
    int n_random;
    shadow_count = 0;
    gap_percent = 0;

    add_row(make_cmd(OP_FLUSH, 0, 0, 0, 0), 1, '{K_FLUSH_EMPTY, 0, 0, 0, 1});
    add_row(make_cmd(OP_ALLOC, 0, 0, 0, 0), 1, '{K_MISS, 0, 1, 0, 1});
    add_row(make_cmd(OP_ALLOC, 32'hFFFF_FFFF, 4'hF, 0, 0), 1, '{K_MISS, 0, 0, 0, 1});
    add_row(make_cmd(OP_ALLOC, 32'h8000_0000, 0, 0, 0), 1,
            '{K_MISS, 0, 32'h8000_0000, 0, 1});
    add_row(make_cmd(OP_ALLOC, 32'h8000_0001, 0, 0, 0), 1, '{K_MISS, 0, 0, 0, 1});
    add_row(make_cmd(OP_ALLOC, 100, 12, 0, 0), 1, '{K_MISS, 0, 4096, 0, 1});
    add_row(make_cmd(OP_FREE, 0, 0, 0, 64), 1, '{K_FREE_REL, 0, 0, 0, 1});
    add_row(make_cmd(OP_NONE, '1, '1, '1, '1), 0, '0);
    add_row(make_cmd(OP_FREE, 0, 0, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF), 0, '0);
    add_row(make_cmd(OP_FREE, 0, 0, 48'h1000, 64), 0, '0);
    add_row(make_cmd(OP_FREE, 0, 0, 48'h2000, 64), 0, '0);
    add_row(make_cmd(OP_FREE, 0, 0, 48'h3008, 8), 0, '0);
    add_row(make_cmd(OP_ALLOC, 16, 4, 0, 0), 0, '0);
    add_row(make_cmd(OP_ALLOC, 0, 0, 0, 0), 0, '0);
    add_row(make_cmd(OP_ALLOC, 32'hFFFF_FFFF, 0, 0, 0), 0, '0);
    for (int i = 1; i <= 17; i++)
      add_row(make_cmd(OP_FREE, 0, 0, 48'(i * 16), 32'(i % 5)), 0, '0);
    add_row(make_cmd(OP_FLUSH, 0, 0, 0, 0), 0, '0);

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].check_it) begin
        predict_pool_command(directed_rows[i].c);
        if (expected_results[$] !== directed_rows[i].r) begin
          $error("row %0d: table expectation disagrees with predictor", i);
          row_errors++;
        end
        // Undo; send_command predicts it again.
        void'(expected_results.pop_back());
        shadow_count = 0;
      end
      send_command(directed_rows[i].c);
    end

    for (int phase = 0; phase < 3; phase++) begin
      gap_percent = (phase == 0) ? 32 : (phase == 1) ? 81 : 0;
      n_random = 0;
      while (n_random < 66) begin
        c = random_cmd();
        send_command(c);
        if (op_t'(c.opcode) != OP_NONE) n_random++;
      end
    end
    start <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && row_errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
